FILE: src/flux_bit_resample_plotter_core_defines.svh
// assertion macros shared by the flux bit resample plotter rtl
// expects signals named clk and rst in the scope of each use
`ifndef FLUX_BIT_RESAMPLE_PLOTTER_CORE_DEFINES_SVH
`define FLUX_BIT_RESAMPLE_PLOTTER_CORE_DEFINES_SVH

// same-cycle implication
`define FBRP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbrp assertion failed");

// next-cycle implication
`define FBRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbrp assertion failed");

`endif

FILE: src/fbrp_pkg.sv
// shared types and constants of the flux bit resample plotter
// no dependencies
package fbrp_pkg;

  localparam int IDX_W       = 24;
  localparam int NUM_REGS    = 5;
  localparam int REG_IDX_W   = 3;
  localparam int TRACK_RESET = 65536;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START  = 3'd0,
    REG_END    = 3'd1,
    REG_TRACK  = 3'd2,
    REG_SOURCE = 3'd3,
    REG_CLAMP  = 3'd4
  } reg_idx_t;

  localparam logic FUNC_BEGIN = 1'b0;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SET   = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIV_HALF = 2'd0,
    DIV_END  = 2'd1,
    DIV_PROD = 2'd2,
    DIV_CELL = 2'd3
  } div_sel_t;

  typedef enum logic [2:0] {
    RES_NONE        = 3'd0,
    RES_CLAMP_RANGE = 3'd1,
    RES_FULL_RANGE  = 3'd2,
    RES_WRAP_LOW    = 3'd3,
    RES_WRAP_HIGH   = 3'd4,
    RES_CELL_CLAMP  = 3'd5,
    RES_CELL_WRAP   = 3'd6
  } res_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     div_start;
    div_sel_t div_sel;
    logic     load_half;
    logic     load_mul;
    logic     load_cell;
    logic     res_load;
    res_sel_t res_sel;
    logic     res_last;
    logic     set_stop;
    logic     clr_stop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic func;
    logic skip;
    logic clamp_path;
    logic wide;
    logic cell_over;
    logic cell_under;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/fbrp_item_if.sv
// input item channel of the flux bit resample plotter
// depends on fbrp_pkg
interface fbrp_item_if;
  import fbrp_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] source_index;
  logic             source_value;

  modport source (output valid, func, source_index, source_value, input ready);
  modport sink (input valid, func, source_index, source_value, output ready);
endinterface

FILE: src/fbrp_result_if.sv
// result channel of the flux bit resample plotter
// depends on fbrp_pkg
interface fbrp_result_if #(
  parameter int CELL_BITS = 24
);
  import fbrp_pkg::*;

  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic [CELL_BITS-1:0] range_first;
  logic [CELL_BITS-1:0] range_end;
  logic [CELL_BITS-1:0] cell_res;
  logic                 halted;
  logic                 last;

  modport source (output valid, kind, range_first, range_end, cell_res, halted, last,
                  input ready);
  modport sink (input valid, kind, range_first, range_end, cell_res, halted, last,
                output ready);
endinterface

FILE: src/fbrp_regs.sv
// apb configuration registers of the flux bit resample plotter
// depends on fbrp_pkg
module fbrp_regs #(
  parameter int CELL_BITS = 24,
  localparam int END_W = CELL_BITS + 1,
  localparam int DATA_W = (END_W > 32) ? 64 : 32,
  localparam int STRIDE = (END_W > 32) ? 8 : 4,
  localparam int ADDR_W = $clog2(fbrp_pkg::NUM_REGS * STRIDE)
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,
  output logic                 cfg_wr,
  output logic [CELL_BITS-1:0] start_cell,
  output logic [END_W-1:0]     end_cell,
  output logic [CELL_BITS-1:0] track_cells,
  output logic [CELL_BITS-1:0] source_cells,
  output logic                 clamp_mode
);
  import fbrp_pkg::*;

  localparam int SHIFT = $clog2(STRIDE);

  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:SHIFT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cell   <= '0;
      end_cell     <= '0;
      track_cells  <= CELL_BITS'(TRACK_RESET);
      source_cells <= CELL_BITS'(1);
      clamp_mode   <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_START:  start_cell   <= pwdata[CELL_BITS-1:0];
        REG_END:    end_cell     <= pwdata[END_W-1:0];
        REG_TRACK:  track_cells  <= pwdata[CELL_BITS-1:0];
        REG_SOURCE: source_cells <= pwdata[CELL_BITS-1:0];
        REG_CLAMP:  clamp_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START:  prdata = DATA_W'(start_cell);
      REG_END:    prdata = DATA_W'(end_cell);
      REG_TRACK:  prdata = DATA_W'(track_cells);
      REG_SOURCE: prdata = DATA_W'(source_cells);
      REG_CLAMP:  prdata = DATA_W'(clamp_mode);
      default:    prdata = '0;
    endcase
  end
endmodule

FILE: src/fbrp_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// no dependencies
module fbrp_div #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 25
)(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             ge;

  // shift in the next numerator bit and try a subtract
  assign trial = {rem_r, acc[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      acc   <= {acc[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quo = acc;
  assign rem = rem_r;
endmodule

FILE: src/fbrp_dp.sv
// datapath: derived span values, product, cell sum, shared divider, result register
// depends on fbrp_pkg and fbrp_div
module fbrp_dp #(
  parameter int CELL_BITS = 24,
  localparam int END_W = CELL_BITS + 1
)(
  input  logic                      clk,
  input  logic                      rst,
  input  logic [CELL_BITS-1:0]      start_cell,
  input  logic [END_W-1:0]          end_cell,
  input  logic [CELL_BITS-1:0]      track_cells,
  input  logic [CELL_BITS-1:0]      source_cells,
  input  logic                      clamp_mode,
  input  logic                      item_func,
  input  logic [fbrp_pkg::IDX_W-1:0] item_index,
  input  logic                      item_value,
  input  fbrp_pkg::ctrl_cmd_t       cmd,
  output fbrp_pkg::dp_stat_t        stat,
  input  logic                      out_ready,
  output logic                      out_valid,
  output fbrp_pkg::kind_t           out_kind,
  output logic [CELL_BITS-1:0]      out_first,
  output logic [CELL_BITS-1:0]      out_end,
  output logic [CELL_BITS-1:0]      out_cell,
  output logic                      out_halted,
  output logic                      out_last
);
  import fbrp_pkg::*;

  localparam int PROD_W = IDX_W + END_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DEN_W  = END_W;

  // derived from configuration, registered in the cycle after it changes
  logic [CELL_BITS-1:0] track_c, track_eff;
  logic [CELL_BITS-1:0] src_c, src_eff;
  logic [END_W-1:0]     width_c, width_r;
  logic [END_W-1:0]     wrap_floor;
  logic [CELL_BITS-1:0] clamp_sel;
  logic                 clamp_path;

  logic [END_W-1:0]     half;
  logic                 func_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 val_r;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     cell_sum;
  logic                 stop;

  logic [SUM_W-1:0]     div_num;
  logic [DEN_W-1:0]     div_den;
  logic                 div_busy;
  logic [SUM_W-1:0]     div_quo;
  logic [DEN_W-1:0]     div_rem;

  logic                 rng;
  logic [CELL_BITS-1:0] rf, re;
  kind_t                kind_n;
  logic [CELL_BITS-1:0] first_n, end_n, cell_n;
  logic                 out_free;

  assign track_c = (track_cells == '0) ? CELL_BITS'(1) : track_cells;
  assign src_c   = (source_cells == '0) ? CELL_BITS'(1) : source_cells;
  assign width_c = (end_cell > {1'b0, start_cell}) ? end_cell - {1'b0, start_cell} : '0;

  always_ff @(posedge clk) begin
    track_eff  <= track_c;
    src_eff    <= src_c;
    width_r    <= width_c;
    wrap_floor <= end_cell - {1'b0, track_c};
    clamp_sel  <= (end_cell < {1'b0, track_c}) ? end_cell[CELL_BITS-1:0] : track_c;
    clamp_path <= clamp_mode | (end_cell <= {1'b0, track_c});
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_HALF: begin
        div_num = SUM_W'(width_r);
        div_den = {src_eff, 1'b0};
      end
      DIV_END: begin
        div_num = SUM_W'(end_cell);
        div_den = {1'b0, track_eff};
      end
      DIV_PROD: begin
        div_num = SUM_W'(prod);
        div_den = {1'b0, src_eff};
      end
      default: begin
        div_num = cell_sum;
        div_den = {1'b0, track_eff};
      end
    endcase
  end

  fbrp_div #(
    .NUM_W (SUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= item_func;
      idx_r  <= item_index;
      val_r  <= item_value;
    end
    if (cmd.load_half) begin
      half <= div_quo[END_W-1:0];
    end
    if (cmd.load_mul) begin
      prod <= PROD_W'(idx_r) * PROD_W'(width_r);
    end
    if (cmd.load_cell) begin
      cell_sum <= SUM_W'(start_cell) + SUM_W'(half) + div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop <= 1'b0;
    end else if (cmd.clr_stop) begin
      stop <= 1'b0;
    end else if (cmd.set_stop) begin
      stop <= 1'b1;
    end
  end

  // result selection; an empty range reads as nothing to write
  always_comb begin
    rng     = 1'b0;
    rf      = '0;
    re      = '0;
    kind_n  = KIND_NONE;
    first_n = '0;
    end_n   = '0;
    cell_n  = '0;
    case (cmd.res_sel)
      RES_CLAMP_RANGE: begin
        rng = 1'b1;
        rf  = start_cell;
        re  = clamp_sel;
      end
      RES_FULL_RANGE: begin
        rng = 1'b1;
        re  = track_eff;
      end
      RES_WRAP_LOW: begin
        rng = 1'b1;
        re  = div_rem[CELL_BITS-1:0];
      end
      RES_WRAP_HIGH: begin
        rng = 1'b1;
        rf  = start_cell;
        re  = track_eff;
      end
      RES_CELL_CLAMP: begin
        kind_n = KIND_SET;
        cell_n = cell_sum[CELL_BITS-1:0];
      end
      RES_CELL_WRAP: begin
        kind_n = KIND_SET;
        cell_n = div_rem[CELL_BITS-1:0];
      end
      default: ;
    endcase
    if (rng && (rf < re)) begin
      kind_n  = KIND_CLEAR;
      first_n = rf;
      end_n   = re;
    end
  end

  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_kind   <= kind_n;
      out_first  <= first_n;
      out_end    <= end_n;
      out_cell   <= cell_n;
      out_halted <= (stop | cmd.set_stop) & ~cmd.clr_stop;
      out_last   <= cmd.res_last;
    end
  end

  assign stat.func       = func_r;
  assign stat.skip       = stop | ~val_r;
  assign stat.clamp_path = clamp_path;
  assign stat.wide       = width_r >= {1'b0, track_eff};
  assign stat.cell_over  = cell_sum >= SUM_W'(track_eff);
  assign stat.cell_under = cell_sum < SUM_W'(wrap_floor);
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = out_free;
endmodule

FILE: src/fbrp_ctrl.sv
// controller state machine of the flux bit resample plotter
// depends on fbrp_pkg
module fbrp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr,
  input  logic                item_valid,
  output logic                item_ready,
  input  fbrp_pkg::dp_stat_t  stat,
  output fbrp_pkg::ctrl_cmd_t cmd
);
  import fbrp_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_PREP      = 10'b00_0000_0010,
    S_HALF      = 10'b00_0000_0100,
    S_DISPATCH  = 10'b00_0000_1000,
    S_END_WAIT  = 10'b00_0001_0000,
    S_WRAP_HIGH = 10'b00_0010_0000,
    S_MUL       = 10'b00_0100_0000,
    S_PROD_WAIT = 10'b00_1000_0000,
    S_CELL      = 10'b01_0000_0000,
    S_MOD_WAIT  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   stale;

  // half-cell offset must be recomputed after any register write; a write
  // landing after the pass has latched its operands keeps the flag up
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stale <= 1'b1;
    end else begin
      state <= state_next;
      stale <= cfg_wr | (stale & (state != S_PREP));
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        if (stale) begin
          if (!cfg_wr) begin
            state_next = S_PREP;
          end
        end else begin
          item_ready = ~cfg_wr;
          if (item_valid && !cfg_wr) begin
            cmd.load_item = 1'b1;
            state_next    = S_DISPATCH;
          end
        end
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_HALF;
        state_next    = S_HALF;
      end
      S_HALF: begin
        if (!stat.div_busy) begin
          cmd.load_half = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DISPATCH: begin
        if (stat.func == FUNC_BEGIN) begin
          if (stat.clamp_path || stat.wide) begin
            if (stat.out_free) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = stat.clamp_path ? RES_CLAMP_RANGE : RES_FULL_RANGE;
              cmd.res_last = 1'b1;
              cmd.clr_stop = 1'b1;
              state_next   = S_IDLE;
            end
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_END;
            cmd.clr_stop  = 1'b1;
            state_next    = S_END_WAIT;
          end
        end else if (stat.skip) begin
          if (stat.out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_NONE;
            cmd.res_last = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.load_mul = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_END_WAIT: begin
        if (!stat.div_busy && stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_WRAP_LOW;
          state_next   = S_WRAP_HIGH;
        end
      end
      S_WRAP_HIGH: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_WRAP_HIGH;
          cmd.res_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PROD;
        state_next    = S_PROD_WAIT;
      end
      S_PROD_WAIT: begin
        if (!stat.div_busy) begin
          cmd.load_cell = 1'b1;
          state_next    = S_CELL;
        end
      end
      S_CELL: begin
        if (stat.clamp_path) begin
          if (stat.out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_last = 1'b1;
            cmd.set_stop = stat.cell_over;
            cmd.res_sel  = stat.cell_over ? RES_NONE : RES_CELL_CLAMP;
            state_next   = S_IDLE;
          end
        end else if (stat.cell_under) begin
          if (stat.out_free) begin
            cmd.res_load = 1'b1;
            cmd.res_last = 1'b1;
            cmd.set_stop = 1'b1;
            cmd.res_sel  = RES_NONE;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_CELL;
          state_next    = S_MOD_WAIT;
        end
      end
      S_MOD_WAIT: begin
        if (!stat.div_busy && stat.out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_CELL_WRAP;
          cmd.res_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

FILE: src/flux_bit_resample_plotter_core.sv
// top level of the flux bit resample plotter: apb registers, controller, datapath
// depends on fbrp_pkg, fbrp_item_if, fbrp_result_if, fbrp_regs, fbrp_ctrl, fbrp_dp
// and the assertion macros in flux_bit_resample_plotter_core_defines.svh
`include "flux_bit_resample_plotter_core_defines.svh"

// Maps the set bits of a source flux segment onto a circular track of track_cells
// cells. A begin item (func 0) rearms the run and returns one or two results, each a
// clear range or nothing to write; a bit item returns exactly one result, a set cell
// at start + width/(2*source) + index*width/source or nothing to write. All divisions
// go through one shared radix-2 divider that retires one quotient bit per cycle over
// a dividend of IDX_W+CELL_BITS+2 (50) bits, and that divider sets the rate. Items
// are handled one at a time: a cleared bit, a stopped run or a clamp/full-width
// begin goes straight to its result; a set bit takes one divider pass on the clamp
// path and two with wrap-around (the cell modulo the track is the second pass); a
// wrapping begin takes one pass. After reset and after each register write the
// block recomputes the half-cell offset in a divider pass before it takes the next
// item; a write that lands during that pass runs it once more. A result waits while
// the output register still holds one not yet taken. A finished result sits in an
// output register, so the next item is accepted while it waits.
module flux_bit_resample_plotter_core #(
  parameter int CELL_BITS = 24,
  localparam int END_W = CELL_BITS + 1,
  localparam int DATA_W = (END_W > 32) ? 64 : 32,
  localparam int STRIDE = (END_W > 32) ? 8 : 4,
  localparam int ADDR_W = $clog2(fbrp_pkg::NUM_REGS * STRIDE)
)(
  input  logic               clk,
  input  logic               rst,
  fbrp_item_if.sink          item,
  fbrp_result_if.source      result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);
  import fbrp_pkg::*;

  // configuration values
  logic                 cfg_wr;
  logic [CELL_BITS-1:0] start_cell;
  logic [END_W-1:0]     end_cell;
  logic [CELL_BITS-1:0] track_cells;
  logic [CELL_BITS-1:0] source_cells;
  logic                 clamp_mode;

  // controller to datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      item_ready;

  // result register outputs
  logic                 out_valid;
  kind_t                out_kind;
  logic [CELL_BITS-1:0] out_first;
  logic [CELL_BITS-1:0] out_end;
  logic [CELL_BITS-1:0] out_cell;
  logic                 out_halted;
  logic                 out_last;

  fbrp_regs #(
    .CELL_BITS (CELL_BITS)
  ) u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cfg_wr       (cfg_wr),
    .start_cell   (start_cell),
    .end_cell     (end_cell),
    .track_cells  (track_cells),
    .source_cells (source_cells),
    .clamp_mode   (clamp_mode)
  );

  // sequencing: accept, dispatch, divider passes, result beats
  fbrp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // span arithmetic, shared divider and the output register
  fbrp_dp #(
    .CELL_BITS (CELL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .start_cell   (start_cell),
    .end_cell     (end_cell),
    .track_cells  (track_cells),
    .source_cells (source_cells),
    .clamp_mode   (clamp_mode),
    .item_func    (item.func),
    .item_index   (item.source_index),
    .item_value   (item.source_value),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (result.ready),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_first    (out_first),
    .out_end      (out_end),
    .out_cell     (out_cell),
    .out_halted   (out_halted),
    .out_last     (out_last)
  );

  assign item.ready         = item_ready;
  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.range_first = out_first;
  assign result.range_end   = out_end;
  assign result.cell_res    = out_cell;
  assign result.halted      = out_halted;
  assign result.last        = out_last;

  // a set cell is never reported once the run has stopped
  `FBRP_ASSERT_SAME(a_set_not_halted, result.valid && (result.kind == KIND_SET), !result.halted)

  // a clear range is never empty
  `FBRP_ASSERT_SAME(a_range_ordered, result.valid && (result.kind == KIND_CLEAR),
                    result.range_first < result.range_end)

  // a new item never starts while the previous one still owes a beat
  `FBRP_ASSERT_SAME(a_accept_after_last, item.valid && item.ready,
                    !(result.valid && !result.last))

  // one item at a time
  `FBRP_ASSERT_NEXT(a_single_item, item.valid && item.ready, !item.ready)

endmodule
